### design/assert_macros.svh
// Assertion macros shared by the vertex welding design.
// Every check samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define SHVD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

### design/shvd_pkg.sv
// Package for the spatial hash vertex welding block.
// Holds field widths, configuration defaults, register codes and shared types.
package shvd_pkg;
  localparam int POS_W         = 24;
  localparam int NORM_W        = 16;
  localparam int SCALE_W       = 24;
  localparam int TOL_W         = 48;
  localparam int IDX_OUT_W     = 14;
  localparam int DEF_GRID_DIM  = 32;
  localparam int DEF_MAX_VERTS = 16384;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_ADDR_W    = 6;

  typedef enum logic [2:0] {
    REG_MIN_X   = 3'd0,
    REG_MIN_Y   = 3'd1,
    REG_MIN_Z   = 3'd2,
    REG_SCALE_X = 3'd3,
    REG_SCALE_Y = 3'd4,
    REG_SCALE_Z = 3'd5,
    REG_TOL     = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [POS_W-1:0] min_x;
    logic signed [POS_W-1:0] min_y;
    logic signed [POS_W-1:0] min_z;
    logic [SCALE_W-1:0]      scale_x;
    logic [SCALE_W-1:0]      scale_y;
    logic [SCALE_W-1:0]      scale_z;
    logic [TOL_W-1:0]        tol;
  } shvd_cfg_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } pos3_t;
endpackage

### design/shvd_ifs.sv
// Valid/ready channel interfaces for vertex words and result words.
// Depends on shvd_pkg for the field widths.
interface shvd_in_if import shvd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic signed [POS_W-1:0]  pos_z;
  logic signed [NORM_W-1:0] norm_x;
  logic signed [NORM_W-1:0] norm_y;
  logic signed [NORM_W-1:0] norm_z;
  modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, output ready);
endinterface

interface shvd_out_if import shvd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [IDX_OUT_W-1:0]     vertex_index;
  logic                     is_new;
  logic                     table_full;
  logic signed [NORM_W-1:0] new_norm_x;
  logic signed [NORM_W-1:0] new_norm_y;
  logic signed [NORM_W-1:0] new_norm_z;
  modport source (output valid, vertex_index, is_new, table_full, new_norm_x, new_norm_y,
                  new_norm_z, input ready);
  modport sink (input valid, vertex_index, is_new, table_full, new_norm_x, new_norm_y,
                new_norm_z, output ready);
endinterface

### design/shvd_cfg.sv
// APB-style configuration registers of the vertex welding block.
// Depends on shvd_pkg for register codes and the configuration struct.
module shvd_cfg import shvd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output shvd_cfg_t             cfg
);
  shvd_cfg_t cfg_r, cfg_nxt;
  reg_idx_t  idx;

  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:3]);
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite) begin
      unique case (idx)
        REG_MIN_X:   cfg_nxt.min_x   = pwdata[POS_W-1:0];
        REG_MIN_Y:   cfg_nxt.min_y   = pwdata[POS_W-1:0];
        REG_MIN_Z:   cfg_nxt.min_z   = pwdata[POS_W-1:0];
        REG_SCALE_X: cfg_nxt.scale_x = pwdata[SCALE_W-1:0];
        REG_SCALE_Y: cfg_nxt.scale_y = pwdata[SCALE_W-1:0];
        REG_SCALE_Z: cfg_nxt.scale_z = pwdata[SCALE_W-1:0];
        REG_TOL:     cfg_nxt.tol     = pwdata[TOL_W-1:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_MIN_X:   prdata = CFG_DATA_W'(cfg_r.min_x);
      REG_MIN_Y:   prdata = CFG_DATA_W'(cfg_r.min_y);
      REG_MIN_Z:   prdata = CFG_DATA_W'(cfg_r.min_z);
      REG_SCALE_X: prdata = CFG_DATA_W'(cfg_r.scale_x);
      REG_SCALE_Y: prdata = CFG_DATA_W'(cfg_r.scale_y);
      REG_SCALE_Z: prdata = CFG_DATA_W'(cfg_r.scale_z);
      REG_TOL:     prdata = CFG_DATA_W'(cfg_r.tol);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end
endmodule

### design/shvd_ram.sv
// Single-port synchronous RAM with a registered read port.
// Self-contained; used for the cell head table and the vertex table.
module shvd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end
endmodule

### design/shvd_dist.sv
// Squared distance unit: registered per-axis squares, then sum and compare.
// Depends on shvd_pkg for the position type and tolerance width.
module shvd_dist import shvd_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  pos3_t            p,
  input  pos3_t            s,
  input  logic [TOL_W-1:0] tol,
  output logic             match
);
  localparam int DW = POS_W + 1;
  localparam int SW = 2 * DW;

  logic signed [DW-1:0] dx, dy, dz;
  logic signed [SW-1:0] qx, qy, qz;
  logic [SW-1:0]        sqx_r, sqy_r, sqz_r;
  logic [SW+1:0]        sum;

  assign dx = DW'(p.x) - DW'(s.x);
  assign dy = DW'(p.y) - DW'(s.y);
  assign dz = DW'(p.z) - DW'(s.z);
  assign qx = dx * dx;
  assign qy = dy * dy;
  assign qz = dz * dz;

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r <= qx;
      sqy_r <= qy;
      sqz_r <= qz;
    end
  end

  assign sum   = (SW+2)'(sqx_r) + (SW+2)'(sqy_r) + (SW+2)'(sqz_r);
  assign match = sum <= (SW+2)'(tol);
endmodule

### design/spatial_hash_vertex_dedup.sv
// Top level of the spatial hash vertex welding block: sequencer, cell mapping
// and the two tables. Depends on shvd_pkg, shvd_ifs, shvd_cfg, shvd_ram, shvd_dist.
//
//   channel  | direction | contents
//   in_vtx   | in        | pos_x/y/z, norm_x/y/z
//   out_res  | out       | vertex_index, is_new, table_full, new_norm_x/y/z
//   cfg APB  | in        | min, scale and tolerance registers
//
// Each vertex is mapped to a cell, then the chain of that cell is walked: for
// every entry the vertex table read, the square stage and the compare run in
// turn until an entry matches, or the vertex is appended or finds the table
// full; an append behind a tail adds a link step. After reset a sweep over
// all GRID_DIM^3 cells (32768 at the default) empties the cell head table
// before the first vertex. A new vertex is taken only in the idle state.
// A stalled result holds the sequencer at its final step only.
module spatial_hash_vertex_dedup import shvd_pkg::*; #(
  parameter int GRID_DIM  = DEF_GRID_DIM,
  parameter int MAX_VERTS = DEF_MAX_VERTS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  shvd_in_if.sink               in_vtx,
  shvd_out_if.source            out_res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);
  `include "assert_macros.svh"

  localparam int NCELLS = GRID_DIM * GRID_DIM * GRID_DIM;
  localparam int HAW    = $clog2(NCELLS);
  localparam int CW     = $clog2(GRID_DIM);
  localparam int PW     = $clog2(MAX_VERTS + 1);
  localparam int IW     = $clog2(MAX_VERTS);
  localparam int VW     = 3 * POS_W + PW;
  localparam int PRW    = POS_W + 1 + SCALE_W + 1;
  localparam int CLW    = PRW - 28;

  typedef enum logic [11:0] {
    S_CLEAR  = 12'b000000000001,
    S_IDLE   = 12'b000000000010,
    S_MUL    = 12'b000000000100,
    S_CELL   = 12'b000000001000,
    S_HEAD   = 12'b000000010000,
    S_HWAIT  = 12'b000000100000,
    S_CHK    = 12'b000001000000,
    S_VWAIT  = 12'b000010000000,
    S_SQ     = 12'b000100000000,
    S_APPEND = 12'b001000000000,
    S_LINK   = 12'b010000000000,
    S_OUT    = 12'b100000000000
  } state_t;

  shvd_cfg_t cfg;
  state_t    state_r, state_nxt;

  pos3_t                    pos_r, cand_r, cand_nxt, tail_pos_r, tail_pos_nxt;
  logic signed [NORM_W-1:0] nx_r, ny_r, nz_r;
  logic signed [PRW-1:0]    prod_x_r, prod_y_r, prod_z_r;
  logic [HAW-1:0]           cell_r, cell_nxt, clr_r, clr_nxt;
  logic [PW-1:0]            ptr_r, ptr_nxt, tail_r, tail_nxt, link_r, link_nxt;
  logic [PW-1:0]            cnt_r, cnt_nxt;
  logic [IW-1:0]            res_idx_r, res_idx_nxt;
  logic                     res_new_r, res_new_nxt, res_full_r, res_full_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [IDX_OUT_W-1:0]     out_idx_r;
  logic                     out_new_r, out_full_r;
  logic signed [NORM_W-1:0] out_nx_r, out_ny_r, out_nz_r;
  logic [31:0]              cell32, idx32;
  logic [CW-1:0]            ci, cj, ck;
  logic [PW-1:0]            ptr_m1, tail_m1;

  logic           h_we, h_re;
  logic [HAW-1:0] h_addr;
  logic [PW-1:0]  h_wdata, h_rdata;
  logic           v_we, v_re;
  logic [IW-1:0]  v_addr;
  logic [VW-1:0]  v_wdata, v_rdata;
  pos3_t          v_pos;
  logic           dist_en, dist_match, out_free;

  function automatic logic [CW-1:0] clamp_cell(input logic signed [PRW-1:0] pr);
    logic [CLW-1:0] c;
    c = pr[PRW-1:28];
    if (pr[PRW-1]) begin
      return '0;
    end else if (c > CLW'(GRID_DIM - 1)) begin
      return CW'(GRID_DIM - 1);
    end else begin
      return c[CW-1:0];
    end
  endfunction

  shvd_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  shvd_ram #(.WIDTH(PW), .DEPTH(NCELLS), .AW(HAW)) u_heads (
    .clk, .we(h_we), .re(h_re), .addr(h_addr), .wdata(h_wdata), .rdata(h_rdata)
  );

  shvd_ram #(.WIDTH(VW), .DEPTH(MAX_VERTS), .AW(IW)) u_verts (
    .clk, .we(v_we), .re(v_re), .addr(v_addr), .wdata(v_wdata), .rdata(v_rdata)
  );

  assign v_pos = v_rdata[VW-1:PW];

  shvd_dist u_dist (
    .clk, .en(dist_en), .p(pos_r), .s(v_pos), .tol(cfg.tol), .match(dist_match)
  );

  assign ci      = clamp_cell(prod_x_r);
  assign cj      = clamp_cell(prod_y_r);
  assign ck      = clamp_cell(prod_z_r);
  assign cell32  = (32'(ck) * 32'(GRID_DIM) + 32'(cj)) * 32'(GRID_DIM) + 32'(ci);
  assign ptr_m1  = ptr_r - PW'(1);
  assign tail_m1 = tail_r - PW'(1);
  assign out_free = !out_valid_r || out_res.ready;
  assign in_vtx.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    cell_nxt     = cell_r;
    ptr_nxt      = ptr_r;
    tail_nxt     = tail_r;
    link_nxt     = link_r;
    cand_nxt     = cand_r;
    tail_pos_nxt = tail_pos_r;
    cnt_nxt      = cnt_r;
    res_idx_nxt  = res_idx_r;
    res_new_nxt  = res_new_r;
    res_full_nxt = res_full_r;
    out_valid_nxt = out_valid_r && !out_res.ready;
    h_we = 1'b0; h_re = 1'b0; h_addr = cell_r; h_wdata = '0;
    v_we = 1'b0; v_re = 1'b0; v_addr = ptr_m1[IW-1:0]; v_wdata = '0;
    dist_en = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        h_we = 1'b1;
        h_addr = clr_r;
        clr_nxt = clr_r + HAW'(1);
        if (clr_r == HAW'(NCELLS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_vtx.valid) state_nxt = S_MUL;
      end
      S_MUL: state_nxt = S_CELL;
      S_CELL: begin
        cell_nxt = cell32[HAW-1:0];
        state_nxt = S_HEAD;
      end
      S_HEAD: begin
        h_re = 1'b1;
        tail_nxt = '0;
        state_nxt = S_HWAIT;
      end
      S_HWAIT: begin
        ptr_nxt = h_rdata;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (ptr_r == '0) begin
          state_nxt = S_APPEND;
        end else begin
          v_re = 1'b1;
          state_nxt = S_VWAIT;
        end
      end
      S_VWAIT: begin
        dist_en = 1'b1;
        link_nxt = v_rdata[PW-1:0];
        cand_nxt = v_pos;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        if (dist_match) begin
          res_idx_nxt = ptr_m1[IW-1:0];
          res_new_nxt = 1'b0;
          res_full_nxt = 1'b0;
          state_nxt = S_OUT;
        end else begin
          tail_nxt = ptr_r;
          tail_pos_nxt = cand_r;
          ptr_nxt = link_r;
          state_nxt = S_CHK;
        end
      end
      S_APPEND: begin
        if (cnt_r == PW'(MAX_VERTS)) begin
          res_idx_nxt = '0;
          res_new_nxt = 1'b0;
          res_full_nxt = 1'b1;
          state_nxt = S_OUT;
        end else begin
          v_we = 1'b1;
          v_addr = cnt_r[IW-1:0];
          v_wdata = {pos_r, PW'(0)};
          h_we = (tail_r == '0);
          h_wdata = cnt_r + PW'(1);
          res_idx_nxt = cnt_r[IW-1:0];
          res_new_nxt = 1'b1;
          res_full_nxt = 1'b0;
          cnt_nxt = cnt_r + PW'(1);
          state_nxt = (tail_r == '0) ? S_OUT : S_LINK;
        end
      end
      S_LINK: begin
        v_we = 1'b1;
        v_addr = tail_m1[IW-1:0];
        v_wdata = {tail_pos_r, cnt_r};
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign idx32 = 32'(res_idx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vtx.valid && in_vtx.ready) begin
      pos_r <= '{x: in_vtx.pos_x, y: in_vtx.pos_y, z: in_vtx.pos_z};
      nx_r  <= in_vtx.norm_x;
      ny_r  <= in_vtx.norm_y;
      nz_r  <= in_vtx.norm_z;
    end
    prod_x_r <= ((POS_W+1)'(pos_r.x) - (POS_W+1)'(cfg.min_x)) * $signed({1'b0, cfg.scale_x});
    prod_y_r <= ((POS_W+1)'(pos_r.y) - (POS_W+1)'(cfg.min_y)) * $signed({1'b0, cfg.scale_y});
    prod_z_r <= ((POS_W+1)'(pos_r.z) - (POS_W+1)'(cfg.min_z)) * $signed({1'b0, cfg.scale_z});
    cell_r     <= cell_nxt;
    ptr_r      <= ptr_nxt;
    tail_r     <= tail_nxt;
    link_r     <= link_nxt;
    cand_r     <= cand_nxt;
    tail_pos_r <= tail_pos_nxt;
    res_idx_r  <= res_idx_nxt;
    res_new_r  <= res_new_nxt;
    res_full_r <= res_full_nxt;
    if (state_r == S_OUT && out_free) begin
      out_idx_r  <= idx32[IDX_OUT_W-1:0];
      out_new_r  <= res_new_r;
      out_full_r <= res_full_r;
      out_nx_r   <= res_new_r ? nx_r : '0;
      out_ny_r   <= res_new_r ? ny_r : '0;
      out_nz_r   <= res_new_r ? nz_r : '0;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.vertex_index = out_idx_r;
  assign out_res.is_new       = out_new_r;
  assign out_res.table_full   = out_full_r;
  assign out_res.new_norm_x   = out_nx_r;
  assign out_res.new_norm_y   = out_ny_r;
  assign out_res.new_norm_z   = out_nz_r;

  `SHVD_ASSERT(a_cnt_bound, cnt_r <= PW'(MAX_VERTS), "vertex count above table size")
  `SHVD_ASSERT(a_cnt_only_append, cnt_r != $past(cnt_r) |-> $past(state_r) == S_APPEND, "count changed outside append")
  `SHVD_ASSERT(a_new_not_full, out_valid_r && out_new_r |-> !out_full_r, "result both new and full")
  `SHVD_ASSERT(a_accept_starts, in_vtx.valid && in_vtx.ready |=> state_r == S_MUL, "accepted word did not start mapping")
endmodule
